FILE: rtl/core/assert_macros.svh
// Assertion helpers, clocked on clk with synchronous active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must never hold.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/core/clbs_pkg.sv
package clbs_pkg;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_INIT8   = 3'd1,
    MODE_INIT4   = 3'd2,
    MODE_COMMAND = 3'd3,
    MODE_DATA    = 3'd4,
    MODE_CURSOR  = 3'd5,
    MODE_ON      = 3'd6,
    MODE_OFF     = 3'd7
  } mode_t;

  localparam logic [1:0] CFG_LINE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_ON_CODE     = 2'd1;
  localparam logic [1:0] CFG_OFF_CODE    = 2'd2;

  localparam logic [6:0] LINE_LENGTH_RST = 7'd16;
  localparam logic [7:0] ON_CODE_RST     = 8'd12;
  localparam logic [7:0] OFF_CODE_RST    = 8'd8;

  localparam logic [5:0] POWER_WAIT  = 6'd30;
  localparam logic [5:0] FIRST_EXTRA = 6'd4;
  localparam logic [3:0] FIRST_STEP  = 4'd1;
  localparam logic [3:0] LAST_STEP   = 4'd8;
  localparam logic [7:0] CURSOR_BIT  = 8'h80;

  typedef struct packed {
    logic [6:0] line_length;
    logic [7:0] on_code;
    logic [7:0] off_code;
  } cfg_t;

  typedef struct packed {
    logic [5:0] wait_count;
    logic [3:0] init_step;
  } state_t;

  typedef struct packed {
    logic       strobe_res;
    logic       reg_select;
    logic [7:0] bus_data;
    logic       busy_res;
    logic       rejected;
  } result_t;

  function automatic logic [5:0] settle_for(input logic [7:0] code);
    settle_for = (code < 8'd4) ? 6'd5 : 6'd1;
  endfunction

  function automatic logic [7:0] init_byte(input logic [3:0] step,
                                           input logic [7:0] on_code,
                                           input logic [7:0] off_code);
    case (step)
      4'd1:    init_byte = 8'h30;
      4'd2:    init_byte = 8'h30;
      4'd3:    init_byte = 8'h30;
      4'd4:    init_byte = 8'h38;
      4'd5:    init_byte = off_code;
      4'd6:    init_byte = 8'h01;
      4'd7:    init_byte = 8'h06;
      default: init_byte = on_code;
    endcase
  endfunction

endpackage

FILE: rtl/core/clbs_step.sv
module clbs_step (
  input  clbs_pkg::mode_t   mode,
  input  logic [7:0]        value,
  input  logic [1:0]        row,
  input  logic [6:0]        col,
  input  clbs_pkg::cfg_t    cfg,
  input  clbs_pkg::state_t  st,
  output clbs_pkg::state_t  st_nxt,
  output clbs_pkg::result_t res
);

  logic       busy;
  logic [5:0] wait_dec;
  logic [7:0] cursor_sum;
  logic [7:0] data;

  assign busy       = (st.wait_count != '0) || (st.init_step != '0);
  assign wait_dec   = (st.wait_count != '0) ? (st.wait_count - 6'd1) : 6'd0;
  // address wraps at 8 bits
  assign cursor_sum = ({1'b0, cfg.line_length} * {6'd0, row}) + {1'b0, col};

  always_comb begin
    st_nxt         = st;
    res            = '0;
    data           = '0;
    if (mode == clbs_pkg::MODE_TICK) begin
      st_nxt.wait_count = wait_dec;
      if (wait_dec == '0 && st.init_step != '0) begin
        data           = clbs_pkg::init_byte(st.init_step, cfg.on_code, cfg.off_code);
        res.strobe_res = 1'b1;
        res.bus_data   = data;
        st_nxt.wait_count = clbs_pkg::settle_for(data) +
          ((st.init_step == clbs_pkg::FIRST_STEP) ? clbs_pkg::FIRST_EXTRA : 6'd0);
        st_nxt.init_step  = (st.init_step >= clbs_pkg::LAST_STEP) ? 4'd0
                                                                  : st.init_step + 4'd1;
      end
    end else if (busy) begin
      res.rejected = 1'b1;
    end else begin
      case (mode)
        clbs_pkg::MODE_INIT8: begin
          st_nxt.wait_count = clbs_pkg::POWER_WAIT;
          st_nxt.init_step  = clbs_pkg::FIRST_STEP;
        end
        clbs_pkg::MODE_INIT4: begin
          st_nxt.wait_count = clbs_pkg::POWER_WAIT;
          st_nxt.init_step  = '0;
        end
        clbs_pkg::MODE_COMMAND: data = value;
        clbs_pkg::MODE_DATA: begin
          data           = value;
          res.reg_select = 1'b1;
        end
        clbs_pkg::MODE_CURSOR: data = cursor_sum | clbs_pkg::CURSOR_BIT;
        clbs_pkg::MODE_ON:     data = cfg.on_code;
        clbs_pkg::MODE_OFF:    data = cfg.off_code;
        default:               data = '0;
      endcase
      if (mode != clbs_pkg::MODE_INIT8 && mode != clbs_pkg::MODE_INIT4) begin
        res.strobe_res    = 1'b1;
        res.bus_data      = data;
        st_nxt.wait_count = res.reg_select ? 6'd1 : clbs_pkg::settle_for(data);
      end
    end
    res.busy_res = (st_nxt.wait_count != '0) || (st_nxt.init_step != '0);
  end

endmodule

FILE: rtl/core/char_lcd_bus_sequencer_top.sv
// Character LCD bus sequencer. Takes one transaction per clock cycle while
// the output is not stalled: an incoming item is captured in an input
// register, evaluated against the sequencer state in the next cycle and
// lands in the result register, from which the result is offered.
// Throughput is set by the single state update per cycle; a waiting result
// holds the item in the input register, so at most two transactions are in
// flight and the input stalls once both registers are full. Time only
// advances through tick items (mode 0); settle waits and the init sequence
// count those ticks. Configuration writes are accepted in any cycle and are
// meant to happen while the block is idle.
`include "assert_macros.svh"

module char_lcd_bus_sequencer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_value,
  input  logic [1:0] in_row,
  input  logic [6:0] in_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_strobe_res,
  output logic       out_reg_select,
  output logic [7:0] out_bus_data,
  output logic       out_busy_res,
  output logic       out_rejected,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic              in_vld_r;
  clbs_pkg::mode_t   mode_r;
  logic [7:0]        value_r;
  logic [1:0]        row_r;
  logic [6:0]        col_r;
  logic              out_vld_r;
  clbs_pkg::result_t res_r;
  clbs_pkg::result_t res_nxt;
  clbs_pkg::state_t  st_r;
  clbs_pkg::state_t  st_nxt;
  clbs_pkg::cfg_t    cfg_r;
  logic              adv;

  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign cfg_ready = 1'b1;

  clbs_step u_step (
    .mode   (mode_r),
    .value  (value_r),
    .row    (row_r),
    .col    (col_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
      cfg_r.line_length <= clbs_pkg::LINE_LENGTH_RST;
      cfg_r.on_code     <= clbs_pkg::ON_CODE_RST;
      cfg_r.off_code    <= clbs_pkg::OFF_CODE_RST;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          clbs_pkg::CFG_LINE_LENGTH: cfg_r.line_length <= cfg_data[6:0];
          clbs_pkg::CFG_ON_CODE:     cfg_r.on_code     <= cfg_data;
          clbs_pkg::CFG_OFF_CODE:    cfg_r.off_code    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r  <= clbs_pkg::mode_t'(in_mode);
      value_r <= in_value;
      row_r   <= in_row;
      col_r   <= in_col;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_strobe_res = res_r.strobe_res;
  assign out_reg_select = res_r.reg_select;
  assign out_bus_data   = res_r.bus_data;
  assign out_busy_res   = res_r.busy_res;
  assign out_rejected   = res_r.rejected;

  `ASSERT_IMPLIES(a_rej_no_strobe, out_vld_r && res_r.rejected, !res_r.strobe_res, "rejected item strobed")
  `ASSERT_IMPLIES(a_rs_needs_strobe, out_vld_r && res_r.reg_select, res_r.strobe_res, "reg_select without transfer")
  `ASSERT_NEVER(a_step_without_wait, st_r.init_step != '0 && st_r.wait_count == '0, "init step pending with no wait")
  `ASSERT_IMPLIES(a_busy_matches_state, $past(adv), res_r.busy_res == ((st_r.wait_count != '0) || (st_r.init_step != '0)), "busy flag disagrees with state")

endmodule
